// ===== src/ftl_pkg.sv =====
// Shared types, character constants and classification functions of the formula token lexer.
package ftl_pkg;

    typedef enum logic [3:0] {
        TOK_END     = 4'd0,
        TOK_IDENT   = 4'd1,
        TOK_NUMBER  = 4'd2,
        TOK_PLUS    = 4'd3,
        TOK_MINUS   = 4'd4,
        TOK_MUL     = 4'd5,
        TOK_DIV     = 4'd6,
        TOK_LPAREN  = 4'd7,
        TOK_RPAREN  = 4'd8,
        TOK_COMMA   = 4'd9,
        TOK_INVALID = 4'd10
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } scan_mode_t;

    localparam int TOKEN_FIELD_BITS = 16;

    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_STAR       = 8'h2A;
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_LPAREN     = 8'h28;
    localparam logic [7:0] CHAR_RPAREN     = 8'h29;
    localparam logic [7:0] CHAR_COMMA      = 8'h2C;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_TAB        = 8'h09;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

    typedef struct packed {
        token_kind_t                 kind;
        logic [TOKEN_FIELD_BITS-1:0] start;
        logic [TOKEN_FIELD_BITS-1:0] length;
        logic                        overflow;
        logic                        last;
    } token_t;

    typedef struct packed {
        logic   first_valid;
        logic   second_valid;
        token_t first;
        token_t second;
    } scan_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
    endfunction

    function automatic token_kind_t single_kind(input logic [7:0] c);
        token_kind_t k;
        unique case (c)
            CHAR_PLUS:   k = TOK_PLUS;
            CHAR_MINUS:  k = TOK_MINUS;
            CHAR_STAR:   k = TOK_MUL;
            CHAR_SLASH:  k = TOK_DIV;
            CHAR_LPAREN: k = TOK_LPAREN;
            CHAR_RPAREN: k = TOK_RPAREN;
            CHAR_COMMA:  k = TOK_COMMA;
            default:     k = TOK_INVALID;
        endcase
        return k;
    endfunction

endpackage

// ===== src/ftl_scan.sv =====
// Scanner state and the per-character decision that yields up to two tokens.
module ftl_scan import ftl_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         advance,
    input  logic [7:0]   char_code,
    input  logic         end_of_text,
    output scan_result_t result
);

    localparam int WIDE_BITS = (POSITION_BITS > TOKEN_FIELD_BITS) ?
                               POSITION_BITS : TOKEN_FIELD_BITS;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    scan_mode_t               mode_reg,  mode_next;
    logic                     dot_reg,   dot_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic                     ovf_reg,   ovf_next;

    logic                     saturated;
    logic [POSITION_BITS-1:0] close_len;
    logic [WIDE_BITS-1:0]     pos_wide, start_wide, len_wide;
    logic [TOKEN_FIELD_BITS-1:0] pos_field, start_field, len_field;

    assign saturated   = (pos_reg == POS_MAX);
    assign close_len   = pos_reg - start_reg;
    assign pos_wide    = WIDE_BITS'(pos_reg);
    assign start_wide  = WIDE_BITS'(start_reg);
    assign len_wide    = WIDE_BITS'(close_len);
    assign pos_field   = pos_wide[TOKEN_FIELD_BITS-1:0];
    assign start_field = start_wide[TOKEN_FIELD_BITS-1:0];
    assign len_field   = len_wide[TOKEN_FIELD_BITS-1:0];

    always_comb begin
        logic   pending;
        logic   hold;
        logic   single;
        logic   emit_ovf;
        token_t close_tok;
        token_t single_tok;
        token_t end_tok;

        mode_next  = mode_reg;
        dot_next   = dot_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        ovf_next   = ovf_reg;
        result     = '0;
        hold       = 1'b0;
        single     = 1'b0;

        pending  = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
        emit_ovf = end_of_text ? ovf_reg : (ovf_reg | saturated);

        close_tok.kind     = (mode_reg == MODE_IDENT) ? TOK_IDENT : TOK_NUMBER;
        close_tok.start    = start_field;
        close_tok.length   = len_field;
        close_tok.overflow = emit_ovf;
        close_tok.last     = 1'b0;

        single_tok.kind     = single_kind(char_code);
        single_tok.start    = pos_field;
        single_tok.length   = TOKEN_FIELD_BITS'(1);
        single_tok.overflow = emit_ovf;
        single_tok.last     = 1'b1;

        end_tok.kind     = TOK_END;
        end_tok.start    = pos_field;
        end_tok.length   = '0;
        end_tok.overflow = emit_ovf;
        end_tok.last     = 1'b1;

        if (end_of_text) begin
            if (pending) begin
                result.first_valid  = 1'b1;
                result.first        = close_tok;
                result.second_valid = 1'b1;
                result.second       = end_tok;
            end else begin
                result.first_valid = 1'b1;
                result.first       = end_tok;
            end
            // The text is finished; the next item starts a fresh one.
            mode_next  = MODE_IDLE;
            dot_next   = 1'b0;
            pos_next   = '0;
            start_next = '0;
            ovf_next   = 1'b0;
        end else begin
            ovf_next = ovf_reg | saturated;
            pos_next = saturated ? pos_reg : pos_reg + POSITION_BITS'(1);

            if (mode_reg == MODE_IDENT &&
                (is_alpha(char_code) || is_digit(char_code) ||
                 char_code == CHAR_UNDERSCORE)) begin
                hold = 1'b1;
            end else if (mode_reg == MODE_NUMBER && is_digit(char_code)) begin
                hold = 1'b1;
            end else if (mode_reg == MODE_NUMBER && char_code == CHAR_DOT && !dot_reg) begin
                hold     = 1'b1;
                dot_next = 1'b1;
            end

            if (!hold) begin
                mode_next = MODE_IDLE;
                dot_next  = 1'b0;
                if (is_space(char_code)) begin
                    single = 1'b0;
                end else if (is_alpha(char_code) || char_code == CHAR_UNDERSCORE) begin
                    mode_next  = MODE_IDENT;
                    start_next = pos_reg;
                end else if (is_digit(char_code) || char_code == CHAR_DOT) begin
                    mode_next  = MODE_NUMBER;
                    dot_next   = (char_code == CHAR_DOT);
                    start_next = pos_reg;
                end else begin
                    single = 1'b1;
                end

                if (pending && single) begin
                    result.first_valid  = 1'b1;
                    result.first        = close_tok;
                    result.second_valid = 1'b1;
                    result.second       = single_tok;
                end else if (pending) begin
                    result.first_valid = 1'b1;
                    result.first       = close_tok;
                    result.first.last  = 1'b1;
                end else if (single) begin
                    result.first_valid = 1'b1;
                    result.first       = single_tok;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            dot_reg   <= 1'b0;
            pos_reg   <= '0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            dot_reg   <= dot_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ===== src/formula_token_lexer_top.sv =====
// Formula token lexer: input register, scanner and two-entry result buffer.
// The first result of an item is registered in the input register and then in the result buffer.
// Throughput: one item per cycle while m_ready stays high and items give at most one
// token each; an item that gives two tokens holds the scanner until the result buffer
// holds one entry that the single result port is taking. Reset is synchronous and active
// low; it empties both buffers and returns the scanner to idle at text position zero.
module formula_token_lexer_top import ftl_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [15:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic        m_position_overflow,
    output logic        m_last_of_run
);

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_eot_reg;
    logic [1:0]   count_reg;
    token_t       slot0_reg, slot1_reg;
    logic         fire;
    logic         pop;
    scan_result_t scan;

    // The scanner may run only when its results fit in what the buffer frees this cycle.
    assign pop     = m_valid && m_ready;
    assign fire    = in_valid_reg &&
                     (count_reg == 2'd0 || (count_reg == 2'd1 && m_ready));
    assign s_ready = !in_valid_reg || fire;

    ftl_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (fire),
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .result      (scan)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= 2'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                count_reg <= 2'(scan.first_valid) + 2'(scan.second_valid);
            end else if (pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_eot_reg  <= s_end_of_text;
        end
        if (fire) begin
            slot0_reg <= scan.first;
            slot1_reg <= scan.second;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    assign m_valid             = (count_reg != 2'd0);
    assign m_token_kind        = slot0_reg.kind;
    assign m_token_start       = slot0_reg.start;
    assign m_token_length      = slot0_reg.length;
    assign m_position_overflow = slot0_reg.overflow;
    assign m_last_of_run       = slot0_reg.last;

endmodule

// ===== src/ftl_checker.sv =====
// Port-level checks of the formula token lexer and their binding to the top level.
module ftl_checker import ftl_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_char_code,
    input logic        s_end_of_text,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_token_kind,
    input logic [15:0] m_token_start,
    input logic [15:0] m_token_length,
    input logic        m_position_overflow,
    input logic        m_last_of_run
);

    logic one_char_kind;
    assign one_char_kind = (m_token_kind == TOK_PLUS)   || (m_token_kind == TOK_MINUS)  ||
                           (m_token_kind == TOK_MUL)    || (m_token_kind == TOK_DIV)    ||
                           (m_token_kind == TOK_LPAREN) || (m_token_kind == TOK_RPAREN) ||
                           (m_token_kind == TOK_COMMA)  || (m_token_kind == TOK_INVALID);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_char_code) && $stable(s_end_of_text))
        else $error("input item changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) &&
        $stable(m_token_start) && $stable(m_token_length) &&
        $stable(m_position_overflow) && $stable(m_last_of_run))
        else $error("result item changed while stalled");

    a_end_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == TOK_END |-> m_token_length == 16'd0 && m_last_of_run)
        else $error("end token must be empty and close its run");

    a_single_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && one_char_kind |-> m_token_length == 16'd1 && m_last_of_run)
        else $error("one-character token has wrong length or run flag");

    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_position_overflow && m_token_kind != TOK_END
        |=> !m_valid || m_position_overflow)
        else $error("overflow flag dropped before the end of the text");

endmodule

bind formula_token_lexer_top ftl_checker u_ftl_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .s_char_code         (s_char_code),
    .s_end_of_text       (s_end_of_text),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_token_kind        (m_token_kind),
    .m_token_start       (m_token_start),
    .m_token_length      (m_token_length),
    .m_position_overflow (m_position_overflow),
    .m_last_of_run       (m_last_of_run)
);
